// File: rtl/mrfo_pkg.sv
package mrfo_pkg;

  localparam int DEF_SLOTS     = 64;
  localparam int DEF_MSG_WIDTH = 64;

  // Fixed field widths of the request, result and config channels
  localparam int DATA_W  = 64;
  localparam int CNT_W   = 7;
  localparam int BYTES_W = 4;
  localparam int CFG_W   = 7;
  localparam int CFG_IDX_W = 1;

  typedef enum logic [1:0] {
    CMD_GIVE  = 2'd0,
    CMD_TAKE  = 2'd1,
    CMD_PUSH  = 2'd2,
    CMD_RESET = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MSG_BYTES = 1'b0,
    REG_CAPACITY  = 1'b1
  } reg_idx_t;

  // Result fields plus memory control, carried from front to back
  typedef struct packed {
    status_t          status;
    logic             dropped;
    logic [CNT_W-1:0] fill_count;
    logic [CNT_W-1:0] free_space;
    logic             wr_en;
    logic             rd_en;
  } res_ctrl_t;

endpackage

// File: rtl/mrfo_if.sv
interface mrfo_in_if;
  logic                         valid;
  logic                         ready;
  mrfo_pkg::cmd_t               cmd;
  logic [mrfo_pkg::DATA_W-1:0]  data_in;

  modport source (output valid, output cmd, output data_in, input ready);
  modport sink   (input valid, input cmd, input data_in, output ready);
endinterface

interface mrfo_out_if;
  logic                         valid;
  logic                         ready;
  mrfo_pkg::status_t            status;
  logic [mrfo_pkg::DATA_W-1:0]  data_out;
  logic                         dropped;
  logic [mrfo_pkg::CNT_W-1:0]   fill_count;
  logic [mrfo_pkg::CNT_W-1:0]   free_space;

  modport source (output valid, output status, output data_out, output dropped,
                  output fill_count, output free_space, input ready);
  modport sink   (input valid, input status, input data_out, input dropped,
                  input fill_count, input free_space, output ready);
endinterface

// File: rtl/mrfo_queue.sv
module mrfo_queue #(
  parameter int WORD_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [WORD_W-1:0] push_word,
  output logic              not_full,
  input  logic              pop,
  output logic              not_empty,
  output logic [WORD_W-1:0] pop_word
);

  logic [WORD_W-1:0] entry_r [2];
  logic              wptr_r, wptr_nxt;
  logic              rptr_r, rptr_nxt;
  logic [1:0]        cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign not_full  = (cnt_r != 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign do_push   = push && not_full;
  assign do_pop    = pop && not_empty;
  assign pop_word  = entry_r[rptr_r];

  always_comb begin
    wptr_nxt = do_push ? ~wptr_r : wptr_r;
    rptr_nxt = do_pop ? ~rptr_r : rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wptr_r] <= push_word;
    end
  end

endmodule

// File: rtl/mrfo_front.sv
module mrfo_front #(
  parameter int SLOTS     = mrfo_pkg::DEF_SLOTS,
  parameter int MSG_WIDTH = mrfo_pkg::DEF_MSG_WIDTH,
  parameter int PTR_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [mrfo_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mrfo_pkg::CFG_W-1:0]        cfg_wdata,
  mrfo_in_if.sink                           in_req,
  input  logic                              q_not_full,
  output logic                              q_push,
  output mrfo_pkg::res_ctrl_t               q_ctrl,
  output logic [PTR_W-1:0]                  q_addr,
  output logic [MSG_WIDTH-1:0]              q_data
);

  localparam int CNT_W = mrfo_pkg::CNT_W;
  localparam int CMP_W = (PTR_W + 1 > CNT_W) ? PTR_W + 1 : CNT_W;
  localparam int CAP_LIMIT = (SLOTS < (2 ** CNT_W) - 1) ? SLOTS : (2 ** CNT_W) - 1;
  localparam logic [CNT_W-1:0] CAP_MAX = CNT_W'(CAP_LIMIT);

  logic [mrfo_pkg::BYTES_W-1:0] msg_bytes_r;
  logic [CNT_W-1:0]             capacity_r;
  logic [PTR_W-1:0]             rd_slot_r, rd_slot_nxt;
  logic [PTR_W-1:0]             wr_slot_r, wr_slot_nxt;
  logic [CNT_W-1:0]             held_r, held_nxt;

  logic [CNT_W-1:0]             cap;
  logic                         over;
  logic [CNT_W-1:0]             held_eff;
  logic [PTR_W-1:0]             rd_eff, wr_eff;
  logic [PTR_W-1:0]             rd_adv, wr_adv;
  logic [mrfo_pkg::BYTES_W-1:0] bytes_eff;
  logic [CNT_W-1:0]             mask_bits;
  logic [MSG_WIDTH-1:0]         mask;
  logic                         accept;

  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p,
                                               input logic [CNT_W-1:0] c);
    logic [CMP_W-1:0] n;
    n = CMP_W'(p) + CMP_W'(1);
    return (n < CMP_W'(c)) ? PTR_W'(n) : '0;
  endfunction

  assign in_req.ready = q_not_full;
  assign accept       = in_req.valid && q_not_full;
  assign q_push       = accept;

  // Clamp capacity into 1..SLOTS, and to at most 127 (the CNT_W limit)
  always_comb begin
    if (capacity_r == '0) begin
      cap = CNT_W'(1);
    end else if (capacity_r > CAP_MAX) begin
      cap = CAP_MAX;
    end else begin
      cap = capacity_r;
    end
  end

  assign over     = (held_r > cap);
  assign held_eff = over ? '0 : held_r;
  assign rd_eff   = over ? '0 : rd_slot_r;
  assign wr_eff   = over ? '0 : wr_slot_r;
  assign rd_adv   = advance(rd_eff, cap);
  assign wr_adv   = advance(wr_eff, cap);

  // Byte count clamps into 1..8; the mask width saturates at MSG_WIDTH
  always_comb begin
    if (msg_bytes_r == '0) begin
      bytes_eff = mrfo_pkg::BYTES_W'(1);
    end else if (msg_bytes_r > mrfo_pkg::BYTES_W'(8)) begin
      bytes_eff = mrfo_pkg::BYTES_W'(8);
    end else begin
      bytes_eff = msg_bytes_r;
    end
    mask_bits = {bytes_eff, 3'b000};
    for (int i = 0; i < MSG_WIDTH; i++) begin
      mask[i] = (i < int'(mask_bits));
    end
  end

  assign q_data = in_req.data_in[MSG_WIDTH-1:0] & mask;

  always_comb begin
    rd_slot_nxt = rd_eff;
    wr_slot_nxt = wr_eff;
    held_nxt    = held_eff;
    q_addr      = wr_eff;
    q_ctrl      = '0;
    q_ctrl.status = mrfo_pkg::ST_OK;
    unique case (in_req.cmd)
      mrfo_pkg::CMD_GIVE: begin
        if (held_eff < cap) begin
          q_ctrl.wr_en = 1'b1;
          wr_slot_nxt  = wr_adv;
          held_nxt     = held_eff + CNT_W'(1);
        end else begin
          q_ctrl.status = mrfo_pkg::ST_FULL;
        end
      end
      mrfo_pkg::CMD_TAKE: begin
        q_addr = rd_eff;
        if (held_eff != '0) begin
          q_ctrl.rd_en = 1'b1;
          rd_slot_nxt  = rd_adv;
          held_nxt     = held_eff - CNT_W'(1);
        end else begin
          q_ctrl.status = mrfo_pkg::ST_EMPTY;
        end
      end
      mrfo_pkg::CMD_PUSH: begin
        q_ctrl.wr_en = 1'b1;
        wr_slot_nxt  = wr_adv;
        if (held_eff >= cap) begin
          // drop the oldest, count stays put
          q_ctrl.dropped = 1'b1;
          rd_slot_nxt    = rd_adv;
        end else begin
          held_nxt = held_eff + CNT_W'(1);
        end
      end
      mrfo_pkg::CMD_RESET: begin
        rd_slot_nxt = '0;
        wr_slot_nxt = '0;
        held_nxt    = '0;
      end
      default: begin
        held_nxt = held_eff;
      end
    endcase
    q_ctrl.fill_count = held_nxt;
    q_ctrl.free_space = cap - held_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      msg_bytes_r <= mrfo_pkg::BYTES_W'(8);
      capacity_r  <= CNT_W'(64);
      rd_slot_r   <= '0;
      wr_slot_r   <= '0;
      held_r      <= '0;
    end else if (cfg_wr_en) begin
      unique case (mrfo_pkg::reg_idx_t'(cfg_index))
        mrfo_pkg::REG_MSG_BYTES: begin
          msg_bytes_r <= cfg_wdata[mrfo_pkg::BYTES_W-1:0];
        end
        mrfo_pkg::REG_CAPACITY: begin
          // new capacity empties the ring
          capacity_r <= cfg_wdata[CNT_W-1:0];
          rd_slot_r  <= '0;
          wr_slot_r  <= '0;
          held_r     <= '0;
        end
        default: begin
          msg_bytes_r <= msg_bytes_r;
        end
      endcase
    end else if (accept) begin
      rd_slot_r <= rd_slot_nxt;
      wr_slot_r <= wr_slot_nxt;
      held_r    <= held_nxt;
    end
  end

endmodule

// File: rtl/mrfo_back.sv
module mrfo_back #(
  parameter int SLOTS     = mrfo_pkg::DEF_SLOTS,
  parameter int MSG_WIDTH = mrfo_pkg::DEF_MSG_WIDTH,
  parameter int PTR_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_not_empty,
  output logic                 q_pop,
  input  mrfo_pkg::res_ctrl_t  q_ctrl,
  input  logic [PTR_W-1:0]     q_addr,
  input  logic [MSG_WIDTH-1:0] q_data,
  mrfo_out_if.source           out_res
);

  logic [MSG_WIDTH-1:0] mem [SLOTS];
  logic [MSG_WIDTH-1:0] rdata_r;
  mrfo_pkg::res_ctrl_t  ctrl_r;
  logic                 valid_r, valid_nxt;
  logic                 load;

  // advance when the output register is empty or being drained
  assign load  = !valid_r || out_res.ready;
  assign q_pop = load && q_not_empty;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = q_not_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      ctrl_r <= q_ctrl;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_ctrl.wr_en) begin
      mem[q_addr] <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      rdata_r <= mem[q_addr];
    end
  end

  assign out_res.valid      = valid_r;
  assign out_res.status     = ctrl_r.status;
  assign out_res.dropped    = ctrl_r.dropped;
  assign out_res.fill_count = ctrl_r.fill_count;
  assign out_res.free_space = ctrl_r.free_space;
  assign out_res.data_out   = ctrl_r.rd_en ? mrfo_pkg::DATA_W'(rdata_r) : '0;

endmodule

// File: rtl/message_ring_fifo_overwrite_top.sv
// channel  | dir | handshake             | payload
// in_req   | in  | valid/ready           | cmd, data_in
// out_res  | out | valid/ready           | status, data_out, dropped, fill_count, free_space
// cfg      | in  | cfg_wr_en, no stall   | cfg_index, cfg_wdata
//
// One request per cycle while in_req is not stalled. The front stage classifies a
// request and updates the ring pointers in the cycle it is accepted; the back
// stage writes or reads the slot memory later, when it pops the request from the
// queue into its output register, from which out_res presents the result.
// A two-entry queue separates the stages; in_req stalls only when it is full,
// which takes two requests waiting behind a result that out_res holds.
// Reset (synchronous, rst_n low) empties the ring; slot contents are not cleared.
module message_ring_fifo_overwrite_top #(
  parameter int SLOTS     = mrfo_pkg::DEF_SLOTS,
  parameter int MSG_WIDTH = mrfo_pkg::DEF_MSG_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [mrfo_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mrfo_pkg::CFG_W-1:0]     cfg_wdata,
  mrfo_in_if.sink                        in_req,
  mrfo_out_if.source                     out_res
);

  localparam int PTR_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CTRL_W = $bits(mrfo_pkg::res_ctrl_t);
  localparam int WORD_W = CTRL_W + PTR_W + MSG_WIDTH;

  logic                 q_push, q_pop, q_not_full, q_not_empty;
  mrfo_pkg::res_ctrl_t  f_ctrl, b_ctrl;
  logic [PTR_W-1:0]     f_addr, b_addr;
  logic [MSG_WIDTH-1:0] f_data, b_data;
  logic [WORD_W-1:0]    push_word, pop_word;

  mrfo_front #(.SLOTS(SLOTS), .MSG_WIDTH(MSG_WIDTH), .PTR_W(PTR_W)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_req     (in_req),
    .q_not_full (q_not_full),
    .q_push     (q_push),
    .q_ctrl     (f_ctrl),
    .q_addr     (f_addr),
    .q_data     (f_data)
  );

  assign push_word = {f_ctrl, f_addr, f_data};

  mrfo_queue #(.WORD_W(WORD_W)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_word (push_word),
    .not_full  (q_not_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_word  (pop_word)
  );

  assign b_ctrl = mrfo_pkg::res_ctrl_t'(pop_word[WORD_W-1 -: CTRL_W]);
  assign b_addr = pop_word[MSG_WIDTH +: PTR_W];
  assign b_data = pop_word[MSG_WIDTH-1:0];

  mrfo_back #(.SLOTS(SLOTS), .MSG_WIDTH(MSG_WIDTH), .PTR_W(PTR_W)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_pop       (q_pop),
    .q_ctrl      (b_ctrl),
    .q_addr      (b_addr),
    .q_data      (b_data),
    .out_res     (out_res)
  );

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid && out_res.status == mrfo_pkg::ST_EMPTY
      |-> out_res.fill_count == '0 && out_res.data_out == '0)
    else $error("empty take reported held messages or data");

  a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid && out_res.status == mrfo_pkg::ST_FULL
      |-> out_res.free_space == '0 && !out_res.dropped)
    else $error("full give reported free space or a drop");

  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid && out_res.dropped |-> out_res.free_space == '0)
    else $error("drop reported while ring not full");

  a_queue_order: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && !q_push |=> q_not_full)
    else $error("front-to-back queue lost space after a pop");

endmodule
